/* design/fsmf_pkg.sv */
// Shared types and constants for the first substring match finder.
`default_nettype none

package fsmf_pkg;

    localparam int unsigned PATTERN_MAX = 16;
    localparam int unsigned PAT_CNT_W   = $clog2(PATTERN_MAX + 1);
    localparam int unsigned TXT_CNT_W   = 16;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_DATA_W  = 24;

    localparam logic [TXT_CNT_W-1:0] TEXT_MAX = TXT_CNT_W'(65535);

    typedef logic [7:0] t_byte;

    typedef enum logic [IN_USER_W-1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_TEXT    = 2'd2
    } t_req;

    typedef struct packed {
        logic clr_pat;
        logic load_pat;
        logic clr_text;
        logic shift_text;
    } t_cell_ctl;

    typedef struct packed {
        logic             pattern_overflow;
        logic             text_overflow;
        logic [POS_W-1:0] match_position;
        logic             found;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

/* design/fsmf_cell.sv */
// One window cell: a pattern byte and a text byte, both shifted along the row.
`default_nettype none

module fsmf_cell
    import fsmf_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_byte     i_pat_byte,
    input  wire       i_pat_valid,
    input  t_byte     i_txt_byte,
    input  wire       i_txt_valid,
    output t_byte     o_pat_byte,
    output logic      o_pat_valid,
    output t_byte     o_txt_byte,
    output logic      o_txt_valid,
    output logic      o_hit
);

    t_byte r_pat_byte;
    logic  r_pat_valid;
    t_byte r_txt_byte;
    logic  r_txt_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_valid <= 1'b0;
            r_txt_valid <= 1'b0;
        end else begin
            if (i_ctl.clr_pat) begin
                r_pat_valid <= 1'b0;
            end else if (i_ctl.load_pat) begin
                r_pat_valid <= i_pat_valid;
            end
            if (i_ctl.clr_text) begin
                r_txt_valid <= 1'b0;
            end else if (i_ctl.shift_text) begin
                r_txt_valid <= i_txt_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pat) begin
            r_pat_byte <= i_pat_byte;
        end
        if (i_ctl.shift_text) begin
            r_txt_byte <= i_txt_byte;
        end
    end

    // compare against the byte entering this cell on the current shift
    assign o_hit       = !r_pat_valid || (i_txt_valid && (r_pat_byte == i_txt_byte));
    assign o_pat_byte  = r_pat_byte;
    assign o_pat_valid = r_pat_valid;
    assign o_txt_byte  = r_txt_byte;
    assign o_txt_valid = r_txt_valid;

endmodule

`default_nettype wire

/* design/first_substring_match_finder.sv */
// Top level of the first substring match finder: cell row, search state, result buffer.
`default_nettype none

// Takes one request per clock cycle while tready is high, clear, pattern byte or text
// byte alike. The pattern (up to 16 bytes, stored newest-first) and the newest 16 text
// bytes shift side by side through a row of 16 cells, each comparing its pattern byte
// with the text byte entering it, so the whole window is checked in the cycle a text
// byte is accepted. The result for a tlast text byte is registered into the output
// register, or the skid entry if that is stalled. A two-entry result buffer keeps the
// slave side ready while one result waits; tready drops only while two results are held.

module first_substring_match_finder
    import fsmf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire  [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  wire                   i_s_tlast,   // is_last
    input  wire  [IN_USER_W-1:0]  i_s_tuser,   // [1:0] req_type
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [0] found, [16:1] match_position,
                                               // [17] text_overflow, [18] pattern_overflow
);

    logic                 r_out_valid;
    t_result              r_out_data;
    logic                 r_skid_valid;
    t_result              r_skid_data;
    logic [PAT_CNT_W-1:0] r_pat_count;
    logic                 r_pat_ovf;
    logic [TXT_CNT_W-1:0] r_text_count;
    logic                 r_match_seen;
    logic [POS_W-1:0]     r_first_pos;
    logic                 r_text_ovf;

    logic                 n_pat_count_en;
    logic                 n_text_ovf;
    logic                 n_match;
    logic [TXT_CNT_W:0]   n_pos_wide;
    logic                 n_res_valid;
    t_result              n_res;

    logic      w_accept;
    t_req      w_req;
    logic      w_pat_full;
    t_cell_ctl w_ctl;
    logic      w_all_hit;

    t_byte               w_pat_chain [PATTERN_MAX+1];
    logic                w_pv_chain  [PATTERN_MAX+1];
    t_byte               w_txt_chain [PATTERN_MAX+1];
    logic                w_tv_chain  [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] w_hit;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_req      = t_req'(i_s_tuser);
    assign w_pat_full = (r_pat_count == PAT_CNT_W'(PATTERN_MAX));

    always_comb begin
        w_ctl = '0;
        if (w_accept) begin
            case (w_req)
                REQ_CLEAR: begin
                    w_ctl.clr_pat  = 1'b1;
                    w_ctl.clr_text = 1'b1;
                end
                REQ_PATTERN: begin
                    w_ctl.load_pat = !w_pat_full;
                end
                REQ_TEXT: begin
                    w_ctl.shift_text = (r_text_count != TEXT_MAX);
                    w_ctl.clr_text   = i_s_tlast;
                end
                default: begin
                    w_ctl = '0;
                end
            endcase
        end
    end

    assign w_pat_chain[0] = i_s_tdata[7:0];
    assign w_pv_chain[0]  = 1'b1;
    assign w_txt_chain[0] = i_s_tdata[7:0];
    assign w_tv_chain[0]  = 1'b1;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        fsmf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_pat_byte  (w_pat_chain[g]),
            .i_pat_valid (w_pv_chain[g]),
            .i_txt_byte  (w_txt_chain[g]),
            .i_txt_valid (w_tv_chain[g]),
            .o_pat_byte  (w_pat_chain[g+1]),
            .o_pat_valid (w_pv_chain[g+1]),
            .o_txt_byte  (w_txt_chain[g+1]),
            .o_txt_valid (w_tv_chain[g+1]),
            .o_hit       (w_hit[g])
        );
    end

    assign w_all_hit = &w_hit;

    always_comb begin
        n_pat_count_en = w_ctl.load_pat;
        n_text_ovf     = r_text_ovf ||
                         (w_accept && (w_req == REQ_TEXT) && !w_ctl.shift_text);
        n_match        = w_ctl.shift_text && !r_match_seen &&
                         (r_pat_count != '0) && w_all_hit;
        n_pos_wide     = {1'b0, r_text_count} + (TXT_CNT_W+1)'(2)
                         - (TXT_CNT_W+1)'(r_pat_count);
        n_res_valid    = w_accept && (w_req == REQ_TEXT) && i_s_tlast;
        n_res.pattern_overflow = r_pat_ovf;
        n_res.text_overflow    = n_text_ovf;
        if (r_pat_count == '0) begin
            n_res.found          = 1'b1;
            n_res.match_position = POS_W'(1);
        end else if (r_match_seen) begin
            n_res.found          = 1'b1;
            n_res.match_position = r_first_pos;
        end else if (n_match) begin
            n_res.found          = 1'b1;
            n_res.match_position = n_pos_wide[POS_W-1:0];
        end else begin
            n_res.found          = 1'b0;
            n_res.match_position = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_count  <= '0;
            r_pat_ovf    <= 1'b0;
            r_text_count <= '0;
            r_match_seen <= 1'b0;
            r_first_pos  <= '0;
            r_text_ovf   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_ctl.clr_pat) begin
                r_pat_count <= '0;
                r_pat_ovf   <= 1'b0;
            end else if (n_pat_count_en) begin
                r_pat_count <= r_pat_count + PAT_CNT_W'(1);
            end else if (w_accept && (w_req == REQ_PATTERN)) begin
                r_pat_ovf <= 1'b1;
            end

            if (w_ctl.clr_text) begin
                r_text_count <= '0;
                r_match_seen <= 1'b0;
                r_first_pos  <= '0;
                r_text_ovf   <= 1'b0;
            end else begin
                r_text_ovf <= n_text_ovf;
                if (w_ctl.shift_text) begin
                    r_text_count <= r_text_count + TXT_CNT_W'(1);
                end
                if (n_match) begin
                    r_match_seen <= 1'b1;
                    r_first_pos  <= n_pos_wide[POS_W-1:0];
                end
            end

            if (!r_out_valid || i_m_tready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= n_res_valid;
                end else begin
                    r_out_valid <= n_res_valid;
                end
            end else if (n_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_data  <= r_skid_data;
                r_skid_data <= n_res;
            end else begin
                r_out_data <= n_res;
            end
        end else if (n_res_valid) begin
            r_skid_data <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W-RESULT_W)'(0), r_out_data};

endmodule

`default_nettype wire

/* design/fsmf_checker.sv */
// Port-level assertions for the first substring match finder, bound to the top level.
`default_nettype none

module fsmf_checker
    import fsmf_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_tvalid,
    input wire                  o_s_tready,
    input wire [IN_DATA_W-1:0]  i_s_tdata,
    input wire                  i_s_tlast,
    input wire [IN_USER_W-1:0]  i_s_tuser,
    input wire                  o_m_tvalid,
    input wire                  i_m_tready,
    input wire [OUT_DATA_W-1:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    a_backpressure_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("slave side stalled with empty result register");

    a_no_pos_without_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] || (o_m_tdata[16:1] == '0)))
        else $error("position reported without a match");

    a_result_from_last_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast &&
                                    (i_s_tuser == REQ_TEXT)))
        else $error("result without a final text transaction");

endmodule

bind first_substring_match_finder fsmf_checker u_fsmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
